// ===== hdl/fractal_hash_noise_height_top_assert.svh =====
// assertion macros for the fractal height top level
// expects clk and arst_n in the scope that includes this file
`ifndef FRACTAL_HASH_NOISE_HEIGHT_TOP_ASSERT_SVH
`define FRACTAL_HASH_NOISE_HEIGHT_TOP_ASSERT_SVH

// same-cycle implication
`define FHNH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication after a fixed number of cycles
`define FHNH_ASSERT_DLY(lbl, ante, dly, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

// ===== hdl/fhnh_pkg.sv =====
// shared types, constants and register codes of the fractal height block
// no dependencies
`default_nettype none

package fhnh_pkg;

	localparam int OCTAVES = 4;
	localparam int MAP_DIM = 4096;

	localparam int TILE_W  = 12;
	localparam int CODE_W  = 16;
	localparam int Q16_W   = 16;
	localparam int SEED_W  = 64;
	localparam int WIDTH_W = 13;
	localparam int ADDR_W  = 24;
	localparam int DIM_W   = 17;
	localparam int FRAC_W  = 8;
	localparam int NOISE_W = 32;

	// sample coordinate carried pre-shifted by the octave index
	localparam int XS_W  = TILE_W + Q16_W + OCTAVES;
	localparam int CX_W  = XS_W - FRAC_W;
	localparam int ACC_W = NOISE_W + OCTAVES;

	// hash constants
	localparam logic [SEED_W-1:0] KEY_X         = 64'h9E3779B185EBCA87;
	localparam logic [SEED_W-1:0] KEY_Y         = 64'hC2B2AE3D27D4EB4F;
	localparam logic [SEED_W-1:0] FMIX_C1       = 64'hFF51AFD7ED558CCD;
	localparam logic [SEED_W-1:0] FMIX_C2       = 64'hC4CEB9FE1A85EC53;
	localparam logic [SEED_W-1:0] OCT_SEED_STEP = 64'h9E37;
	localparam int FMIX_SH = 33;

	// scaling: weight sum, bias and reciprocal of the weight sum
	localparam int NSUM     = (1 << OCTAVES) - 1;
	localparam int BIAS_SH  = Q16_W + 1;
	localparam int PROD_W   = ACC_W + Q16_W;
	localparam int V_W      = ACC_W + Q16_W + 2;
	localparam int Q_W      = V_W - NOISE_W;
	localparam int RECIP_SH = Q_W + OCTAVES;
	localparam int RECIP_W  = Q_W + 2;
	localparam int F_W      = Q_W + RECIP_W - RECIP_SH;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((longint'(1) << RECIP_SH) + longint'(NSUM) - longint'(1)) / longint'(NSUM));

	// latency
	localparam int FRONT_LAT = 2;
	localparam int CELL_LAT  = 7;
	localparam int SCALE_LAT = 4;
	localparam int PIPE_LAT  = FRONT_LAT + OCTAVES * CELL_LAT + SCALE_LAT;

	// register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_REGION_ID  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_ROUGHNESS  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_BASE_LEVEL = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_SPREAD     = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = CFG_IDX_W'(5);

	typedef struct packed {
		logic [TILE_W-1:0] tile_x;
		logic [TILE_W-1:0] tile_y;
		logic [CODE_W-1:0] palette_code;
	} tile_t;

	typedef struct packed {
		logic              write_height;
		logic [Q16_W-1:0]  height;
		logic [ADDR_W-1:0] tile_address;
	} result_t;

	typedef struct packed {
		logic [SEED_W-1:0]  noise_seed;
		logic [CODE_W-1:0]  region_id;
		logic [Q16_W-1:0]   roughness;
		logic [Q16_W-1:0]   base_level;
		logic [Q16_W-1:0]   spread;
		logic [WIDTH_W-1:0] map_width;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		noise_seed: '0,
		region_id:  '0,
		roughness:  16'd256,
		base_level: 16'd26214,
		spread:     16'd6554,
		map_width:  13'd4096
	};

	// word handed from cell to cell
	typedef struct packed {
		logic              hit;
		logic [ADDR_W-1:0] addr;
		logic [XS_W-1:0]   xs;
		logic [XS_W-1:0]   ys;
		logic [ACC_W-1:0]  acc;
	} cell_word_t;

endpackage

`default_nettype wire

// ===== hdl/fractal_hash_noise_height_top.sv =====
// top level of the fractal height block: config registers, front stage,
// chain of octave cells and output scaling; depends on fhnh_pkg and the
// front, cell and scale modules
//
//  channel   signals                          direction  handshake
//  tile      start, busy, tile                in         taken when start and not busy
//  result    done, result                     out        one-cycle strobe, no back-pressure
//  config    cfg_we, cfg_index, cfg_wdata     in         written when cfg_we is high
//
// one tile word per clock while busy is low; each result word passes through two front
// stages, a chain of four seven-stage octave cells and four scaling stages
// busy is high during reset and until the first clock edge after release, low otherwise
// nothing stalls: the result side takes every word
`default_nettype none

`include "fractal_hash_noise_height_top_assert.svh"

module fractal_hash_noise_height_top import fhnh_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  tile_t                tile,
	output logic                 done,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SEED_W-1:0]    cfg_wdata
);

	cfg_t cfg_q;
	logic busy_q;
	logic take;

	logic              vld_c  [OCTAVES+1];
	cell_word_t        word_c [OCTAVES+1];
	logic [SEED_W-1:0] key_c  [OCTAVES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NOISE_SEED: cfg_q.noise_seed <= cfg_wdata;
				REG_REGION_ID:  cfg_q.region_id  <= cfg_wdata[CODE_W-1:0];
				REG_ROUGHNESS:  cfg_q.roughness  <= cfg_wdata[Q16_W-1:0];
				REG_BASE_LEVEL: cfg_q.base_level <= cfg_wdata[Q16_W-1:0];
				REG_SPREAD:     cfg_q.spread     <= cfg_wdata[Q16_W-1:0];
				REG_MAP_WIDTH:  cfg_q.map_width  <= cfg_wdata[WIDTH_W-1:0];
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	assign busy     = busy_q;
	assign take     = start && !busy_q;
	assign key_c[0] = cfg_q.noise_seed;

	fhnh_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.tile   (tile),
		.cfg    (cfg_q),
		.vld    (vld_c[0]),
		.word   (word_c[0])
	);

	for (genvar gi = 0; gi < OCTAVES; gi++) begin : g_cell
		fhnh_octave_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.key_in   (key_c[gi]),
			.key_out  (key_c[gi+1]),
			.vld_in   (vld_c[gi]),
			.word_in  (word_c[gi]),
			.vld_out  (vld_c[gi+1]),
			.word_out (word_c[gi+1])
		);
	end

	fhnh_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.vld_in     (vld_c[OCTAVES]),
		.word_in    (word_c[OCTAVES]),
		.base_level (cfg_q.base_level),
		.spread     (cfg_q.spread),
		.done       (done),
		.result     (result)
	);

	`FHNH_ASSERT_DLY(a_latency, start && !busy, PIPE_LAT, done, "tile word gave no result in time")
	`FHNH_ASSERT_IMP(a_no_stray, done, $past(start && !busy, PIPE_LAT), "result word with no tile")
	`FHNH_ASSERT_IMP(a_miss_zero, done && !result.write_height,
		result.height == '0 && result.tile_address == '0, "no-write word not cleared")

endmodule

`default_nettype wire

// ===== hdl/fhnh_front.sv =====
// input stage: region match, roughness products and tile address
// depends on fhnh_pkg
`default_nettype none

module fhnh_front import fhnh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  tile_t      tile,
	input  cfg_t       cfg,
	output logic       vld,
	output cell_word_t word
);

	localparam int XR_W = TILE_W + Q16_W;
	localparam int YW_W = TILE_W + WIDTH_W;

	logic            vld_s1;
	logic            vld_s2;
	logic [XR_W-1:0] xr_s1;
	logic [XR_W-1:0] yr_s1;
	logic [YW_W-1:0] yw_s1;
	logic [TILE_W-1:0] x_s1;
	logic            hit_s1;
	cell_word_t      word_s2;

	logic code_match;
	logic x_inside;
	logic y_inside;
	logic hit_c;

	always_comb begin
		// code minus two equals region; ids near the top never match
		code_match = ({1'b0, tile.palette_code} == ({1'b0, cfg.region_id} + (CODE_W+1)'(2)));
		x_inside   = ({{(WIDTH_W-TILE_W){1'b0}}, tile.tile_x} < cfg.map_width);
		y_inside   = (DIM_W'(tile.tile_y) < DIM_W'(MAP_DIM));
		hit_c      = code_match && (cfg.noise_seed != '0) && x_inside && y_inside;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		xr_s1  <= tile.tile_x * cfg.roughness;
		yr_s1  <= tile.tile_y * cfg.roughness;
		yw_s1  <= tile.tile_y * cfg.map_width;
		x_s1   <= tile.tile_x;
		hit_s1 <= hit_c;

		word_s2.hit  <= hit_s1;
		word_s2.addr <= ADDR_W'({1'b0, yw_s1} + (YW_W+1)'(x_s1));
		word_s2.xs   <= XS_W'(xr_s1);
		word_s2.ys   <= XS_W'(yr_s1);
		word_s2.acc  <= '0;
	end

	assign vld  = vld_s2;
	assign word = word_s2;

endmodule

`default_nettype wire

// ===== hdl/fhnh_octave_cell.sv =====
// one octave cell: hashes its sample cell and folds the noise into the sum
// depends on fhnh_pkg
`default_nettype none

module fhnh_octave_cell import fhnh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SEED_W-1:0] key_in,
	output logic [SEED_W-1:0] key_out,
	input  logic              vld_in,
	input  cell_word_t        word_in,
	output logic              vld_out,
	output cell_word_t        word_out
);

	// low 64 bits of a 64 x 64 product as three 32 x 32 partial products
	typedef struct packed {
		logic [63:0] lo;
		logic [31:0] mid_a;
		logic [31:0] mid_b;
	} pp_t;

	function automatic pp_t mul_pp(input logic [63:0] a, input logic [63:0] k);
		pp_t p;
		p.lo    = a[31:0] * k[31:0];
		p.mid_a = 32'(a[31:0] * k[63:32]);
		p.mid_b = 32'(a[63:32] * k[31:0]);
		return p;
	endfunction

	function automatic logic [63:0] pp_sum(input pp_t p);
		logic [31:0] mid;
		mid = p.mid_a + p.mid_b;
		return p.lo + {mid, 32'b0};
	endfunction

	logic [SEED_W-1:0] key_q;

	logic [CELL_LAT-1:0] vld_q;
	cell_word_t word_s1, word_s2, word_s3, word_s4, word_s5, word_s6, word_s7;

	pp_t               px_s1, py_s1;
	logic [63:0]       h_s2;
	pp_t               pa_s3;
	logic [63:0]       h_s4;
	pp_t               pb_s5;
	logic [NOISE_W-1:0] n_s6;

	logic [CX_W-1:0] cx;
	logic [CX_W-1:0] cy;
	logic [63:0]     hk;
	logic [63:0]     g1;
	logic [63:0]     g2;

	always_comb begin
		cx = word_in.xs[XS_W-1:FRAC_W];
		cy = word_in.ys[XS_W-1:FRAC_W];
		hk = key_in ^ pp_sum(px_s1) ^ pp_sum(py_s1);
		g1 = pp_sum(pa_s3);
		g2 = pp_sum(pb_s5);
	end

	// next octave hashes with the key one step on
	always_ff @(posedge clk) begin
		key_q <= key_in + OCT_SEED_STEP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[CELL_LAT-2:0], vld_in};
		end
	end

	always_ff @(posedge clk) begin
		px_s1   <= mul_pp(64'(cx), KEY_X);
		py_s1   <= mul_pp(64'(cy), KEY_Y);
		word_s1 <= word_in;

		h_s2    <= hk ^ (hk >> FMIX_SH);
		word_s2 <= word_s1;

		pa_s3   <= mul_pp(h_s2, FMIX_C1);
		word_s3 <= word_s2;

		h_s4    <= g1 ^ (g1 >> FMIX_SH);
		word_s4 <= word_s3;

		pb_s5   <= mul_pp(h_s4, FMIX_C2);
		word_s5 <= word_s4;

		// only the low half of the last mix is kept as noise
		n_s6    <= g2[NOISE_W-1:0] ^ NOISE_W'(g2 >> FMIX_SH);
		word_s6 <= word_s5;

		// horner form: earlier octaves end up with the heavier weights
		word_s7.hit  <= word_s6.hit;
		word_s7.addr <= word_s6.addr;
		word_s7.xs   <= word_s6.xs << 1;
		word_s7.ys   <= word_s6.ys << 1;
		word_s7.acc  <= (word_s6.acc << 1) + ACC_W'(n_s6);
	end

	assign key_out  = key_q;
	assign vld_out  = vld_q[CELL_LAT-1];
	assign word_out = word_s7;

endmodule

`default_nettype wire

// ===== hdl/fhnh_scale.sv =====
// output stage: centres and scales the octave sum, divides by the weight sum
// and clamps; depends on fhnh_pkg
`default_nettype none

module fhnh_scale import fhnh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vld_in,
	input  cell_word_t       word_in,
	input  logic [Q16_W-1:0] base_level,
	input  logic [Q16_W-1:0] spread,
	output logic             done,
	output result_t          result
);

	localparam int SPAN_W = BIAS_SH + 2;
	localparam int BMUL_W = SPAN_W + OCTAVES;
	localparam logic [F_W:0] LVL_OFFSET = (F_W+1)'(1) << BIAS_SH;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic hit_s1, hit_s2, hit_s3;
	logic [ADDR_W-1:0] addr_s1, addr_s2, addr_s3;

	logic [PROD_W-1:0]        prod_s1;
	logic [Q_W-1:0]           v_s2;
	logic [Q_W+RECIP_W-1:0]   qq_s3;
	result_t                  result_s4;

	logic [SPAN_W-1:0] span;
	logic [BMUL_W-1:0] bias_mul;
	logic [V_W-1:0]    bias;
	logic [V_W-1:0]    vsum;
	logic [F_W-1:0]    f;
	logic [F_W:0]      lvl;
	logic [F_W:0]      above;
	logic [Q16_W-1:0]  clamped;

	always_comb begin
		// bias keeps the centred product non-negative ahead of the floor divide
		span     = (SPAN_W'(1) << (BIAS_SH + 1)) - SPAN_W'(spread);
		bias_mul = BMUL_W'(span) * BMUL_W'(NSUM);
		bias     = V_W'(bias_mul) << (NOISE_W - 1);
		vsum     = V_W'(prod_s1) + bias;

		f     = qq_s3[RECIP_SH +: F_W];
		lvl   = (F_W+1)'(base_level) + (F_W+1)'(f);
		above = lvl - LVL_OFFSET;
		if (lvl < LVL_OFFSET) begin
			clamped = '0;
		end else if (above[F_W:Q16_W] != '0) begin
			clamped = '1;
		end else begin
			clamped = above[Q16_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= word_in.acc * spread;
		hit_s1  <= word_in.hit;
		addr_s1 <= word_in.addr;

		v_s2    <= vsum[V_W-1:NOISE_W];
		hit_s2  <= hit_s1;
		addr_s2 <= addr_s1;

		// floor divide by the weight sum through its reciprocal
		qq_s3   <= v_s2 * RECIP;
		hit_s3  <= hit_s2;
		addr_s3 <= addr_s2;

		if (hit_s3) begin
			result_s4.write_height <= 1'b1;
			result_s4.height       <= clamped;
			result_s4.tile_address <= addr_s3;
		end else begin
			result_s4 <= '0;
		end
	end

	assign done   = vld_s4;
	assign result = result_s4;

endmodule

`default_nettype wire
